// ===== sv/pctu8_pkg.sv =====
// Shared type, constants and helper function of the percent unescape block.
`default_nettype none
package pctu8_pkg;

   // Hex escape phase codes.
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_FIRST  = 2'd1;
   localparam logic [1:0] PH_SECOND = 2'd2;

   // Character and byte constants.
   localparam logic [7:0] CHR_PERCENT = 8'h25;
   localparam logic [7:0] CHR_PLUS    = 8'h2B;
   localparam logic [7:0] CHR_SPACE   = 8'h20;
   localparam logic [7:0] BYTE_ASCII_MAX = 8'h7F;
   localparam logic [7:0] BYTE_CONT_LO   = 8'h80;
   localparam logic [7:0] BYTE_LEAD_LO   = 8'hC0;
   localparam logic [7:0] BYTE_LEAD3     = 8'hE0;
   localparam logic [7:0] BYTE_LEAD4     = 8'hF0;
   localparam logic [7:0] BYTE_LEAD_MAX  = 8'hF7;
   localparam logic [7:0] BYTE_PREFIX    = 8'hC2;
   localparam logic [7:0] REPL_0 = 8'hEF;
   localparam logic [7:0] REPL_1 = 8'hBF;
   localparam logic [7:0] REPL_2 = 8'hBD;

   // Bytes in the longest burst one input word can release.
   localparam int BURST_MAX = 4;
   localparam int QUEUE_DEPTH = 2;

   // One burst of result words caused by a single input word.
   typedef struct packed {
      logic [2:0]                 count;       // zero means a bare end marker
      logic [BURST_MAX-1:0][7:0]  bytes;
      logic                       last;
      logic                       valid;
   } burst_type;

   // Returns {is_digit, nibble}.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/pctu8_front.sv =====
// Front end: escape decoding and UTF-8 repair, one input word per cycle into bursts while the queue has room.
`default_nettype none
module pctu8_front
   import pctu8_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            push,
   output burst_type       push_burst,
   input  wire logic       queue_ready
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] nib_ff, nib_in;
   logic [7:0] held_ff [3];
   logic [1:0] held_cnt_ff, held_cnt_in;
   logic [1:0] cont_ff, cont_in;
   logic       ended_ff, ended_in;
   logic       invalid_ff, invalid_in;

   logic       held_we;
   logic [1:0] held_idx;
   logic       prod_en;
   logic [7:0] prod_c;
   logic [4:0] hd;
   logic       accept;
   logic [15:0] cp3;
   logic [20:0] cp4;
   burst_type  burst;

   assign req_ready = queue_ready;
   assign accept    = req_valid && req_ready;

   // Hex escape decoding and UTF-8 fixing for the current word.
   always_comb begin
      phase_in    = phase_ff;
      nib_in      = nib_ff;
      held_cnt_in = held_cnt_ff;
      cont_in     = cont_ff;
      ended_in    = ended_ff;
      invalid_in  = invalid_ff;
      held_we     = 1'b0;
      held_idx    = 2'd0;
      prod_en     = 1'b0;
      prod_c      = 8'd0;
      hd          = hex_digit(req_in_byte);
      burst       = '0;
      burst.bytes = {BURST_MAX{prod_c}};
      cp3         = 16'd0;
      cp4         = 21'd0;

      // Escape stage.
      if (!ended_ff) begin
         if (phase_ff == PH_FIRST || phase_ff == PH_SECOND) begin
            if (hd[4]) begin
               if (phase_ff == PH_SECOND) begin
                  prod_en  = 1'b1;
                  prod_c   = {nib_ff, hd[3:0]};
                  phase_in = PH_IDLE;
                  nib_in   = 4'd0;
               end else begin
                  phase_in = PH_SECOND;
                  nib_in   = hd[3:0];
               end
            end else begin
               phase_in = PH_IDLE;
               nib_in   = 4'd0;
               if (req_in_byte > BYTE_ASCII_MAX) begin
                  prod_en = 1'b1;
                  prod_c  = req_in_byte;
               end
            end
         end else begin
            phase_in = PH_IDLE;
            if (req_in_byte == CHR_PERCENT) begin
               phase_in = PH_FIRST;
               nib_in   = 4'd0;
            end else if (req_in_byte == CHR_PLUS) begin
               prod_en = 1'b1;
               prod_c  = CHR_SPACE;
            end else begin
               prod_en = 1'b1;
               prod_c  = req_in_byte;
            end
         end
      end

      // UTF-8 repair stage.
      if (prod_en) begin
         if (cont_ff != 2'd0) begin
            if (prod_c[7:6] == 2'b10) begin
               if (cont_ff == 2'd1) begin
                  // Sequence complete: release held bytes and this one.
                  burst.bytes = {BURST_MAX{prod_c}};
                  for (int i = 0; i < 3; i++) begin
                     if (2'(i) < held_cnt_ff) begin
                        burst.bytes[i] = held_ff[i];
                     end
                  end
                  burst.count = {1'b0, held_cnt_ff} + 3'd1;
                  cp3 = {held_ff[0][3:0], held_ff[1][5:0], prod_c[5:0]};
                  cp4 = {held_ff[0][2:0], held_ff[1][5:0], held_ff[2][5:0], prod_c[5:0]};
                  if (held_cnt_ff == 2'd1) begin
                     if (held_ff[0][4:1] == 4'd0) begin
                        invalid_in = 1'b1;
                     end
                  end else if (held_cnt_ff == 2'd2) begin
                     if (cp3 < 16'h0800 || cp3[15:11] == 5'b11011) begin
                        invalid_in = 1'b1;
                     end
                  end else begin
                     if (cp4 < 21'h010000 || cp4 > 21'h10FFFF) begin
                        invalid_in = 1'b1;
                     end
                  end
                  held_cnt_in = 2'd0;
                  cont_in     = 2'd0;
               end else begin
                  held_we     = 1'b1;
                  held_idx    = held_cnt_ff;
                  held_cnt_in = held_cnt_ff + 2'd1;
                  cont_in     = cont_ff - 2'd1;
               end
            end else begin
               // Interrupted sequence becomes the replacement character.
               burst.count    = 3'd3;
               burst.bytes[0] = REPL_0;
               burst.bytes[1] = REPL_1;
               burst.bytes[2] = REPL_2;
               held_cnt_in    = 2'd0;
               cont_in        = 2'd0;
            end
         end else if (prod_c == 8'd0) begin
            ended_in = 1'b1;
         end else if (prod_c <= BYTE_ASCII_MAX) begin
            burst.count    = 3'd1;
            burst.bytes[0] = prod_c;
         end else if (prod_c < BYTE_LEAD_LO) begin
            burst.count    = 3'd2;
            burst.bytes[0] = BYTE_PREFIX;
            burst.bytes[1] = prod_c;
         end else if (prod_c > BYTE_LEAD_MAX) begin
            burst.count = 3'd0;
         end else begin
            held_we     = 1'b1;
            held_idx    = 2'd0;
            held_cnt_in = 2'd1;
            if (prod_c < BYTE_LEAD3) begin
               cont_in = 2'd1;
            end else if (prod_c < BYTE_LEAD4) begin
               cont_in = 2'd2;
            end else begin
               cont_in = 2'd3;
            end
         end
      end

      burst.last  = req_in_last;
      burst.valid = !invalid_in;

      // The last word of a string returns everything to its idle state.
      if (req_in_last) begin
         phase_in    = PH_IDLE;
         nib_in      = 4'd0;
         held_cnt_in = 2'd0;
         cont_in     = 2'd0;
         ended_in    = 1'b0;
         invalid_in  = 1'b0;
      end
   end

   assign push       = accept && (burst.count != 3'd0 || req_in_last);
   assign push_burst = burst;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         nib_ff      <= 4'd0;
         held_cnt_ff <= 2'd0;
         cont_ff     <= 2'd0;
         ended_ff    <= 1'b0;
         invalid_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         nib_ff      <= nib_in;
         held_cnt_ff <= held_cnt_in;
         cont_ff     <= cont_in;
         ended_ff    <= ended_in;
         invalid_ff  <= invalid_in;
      end
   end

   // Held sequence bytes, written before they are read.
   always_ff @(posedge clock) begin
      if (accept && held_we) begin
         held_ff[held_idx] <= prod_c;
      end
   end

endmodule
`default_nettype wire

// ===== sv/pctu8_queue.sv =====
// Two-entry burst queue between the front end and the output sequencer.
`default_nettype none
module pctu8_queue
   import pctu8_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  burst_type      push_burst,
   output logic           push_ready,
   input  wire logic      pop,
   output logic           head_valid,
   output burst_type      head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   burst_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_burst;
      end
   end

endmodule
`default_nettype wire

// ===== sv/pctu8_back.sv =====
// Output sequencer: walks one burst out as individual result words.
`default_nettype none
module pctu8_back
   import pctu8_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  burst_type       head,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_present,
   output logic            rsp_end_of_string,
   output logic            rsp_string_valid
);

   logic [1:0] idx_ff, idx_in;
   logic [2:0] words;
   logic       final_word;
   logic       accept;

   // A burst with no bytes still yields one end marker word.
   assign words      = (head.count == 3'd0) ? 3'd1 : head.count;
   assign final_word = ({1'b0, idx_ff} == words - 3'd1);
   assign accept     = rsp_valid && rsp_ready;
   assign pop        = accept && final_word;
   assign idx_in     = final_word ? 2'd0 : idx_ff + 2'd1;

   assign rsp_valid         = head_valid;
   assign rsp_byte_present  = head.count != 3'd0;
   assign rsp_out_byte      = rsp_byte_present ? head.bytes[idx_ff] : 8'd0;
   assign rsp_end_of_string = head.last && final_word;
   assign rsp_string_valid  = head.last && final_word && head.valid;

   // Position within the current burst.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else if (accept) begin
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/percent_unescape_utf8_repair.sv =====
// Top level of the percent unescape and UTF-8 repair block.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_ready   | req_in_byte[7:0], req_in_last
//  rsp     | out       | rsp_valid/rsp_ready   | rsp_out_byte[7:0], rsp_byte_present,
//          |           |                       | rsp_end_of_string, rsp_string_valid
//
// The front end decodes one input word per cycle while the queue has room and
// pushes the burst it causes (one to four bytes, or a bare end marker) into a
// two-entry queue. The output sequencer sends one result word per cycle while
// rsp_ready is high and pops a burst with its last word; single-byte traffic
// runs at one a cycle; a burst is registered in the queue before it is sent.
// Reset is synchronous; it empties the queue and clears all control state.
// A stall on rsp backs up the queue; req_ready drops only when the queue is full.
`default_nettype none
module percent_unescape_utf8_repair
   import pctu8_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_present,
   output logic            rsp_end_of_string,
   output logic            rsp_string_valid
);

   logic      push, queue_ready, pop, head_valid;
   burst_type push_burst, head;

   pctu8_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .push        (push),
      .push_burst  (push_burst),
      .queue_ready (queue_ready)
   );

   pctu8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_burst (push_burst),
      .push_ready (queue_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   pctu8_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_present  (rsp_byte_present),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_string_valid  (rsp_string_valid)
   );

endmodule
`default_nettype wire

// ===== sv/pctu8_checker.sv =====
// Port-level checks of the percent unescape block and their binding.
`default_nettype none
module pctu8_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_byte_present,
   input wire logic       rsp_end_of_string,
   input wire logic       rsp_string_valid
);

   // A stalled result word stays valid and holds its byte and end flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_end_of_string))
      else $error("result word changed while stalled");

   // A word without a byte is only ever an end marker with a zero byte.
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_present |-> rsp_end_of_string && rsp_out_byte == 8'd0)
      else $error("bare word that is not an end marker");

   // The validity flag appears only on the final word of a string.
   a_valid_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_valid |-> rsp_end_of_string)
      else $error("string_valid on a non-final word");

   // Reset leaves no result pending and the input open.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result pending after reset");

endmodule

bind percent_unescape_utf8_repair pctu8_checker u_pctu8_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_byte_present  (rsp_byte_present),
   .rsp_end_of_string (rsp_end_of_string),
   .rsp_string_valid  (rsp_string_valid)
);
`default_nettype wire
